// ===== hdl/hds_pkg.sv =====
package hds_pkg;

    localparam int MAX_CELLS  = 4096;
    localparam int TEMP_WIDTH = 32;

    localparam int OP_W    = 2;
    localparam int CELL_W  = 12;
    localparam int SLOT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FACES   = 6;
    localparam int GAIN_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_INIT = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LINK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INLET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OUTLET = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_F1_INIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_F2_INIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_F1_IN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_F1_OUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_F2_IN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_F2_OUT = 3'd7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_dat;
    typedef logic [IN_DATA_W-1:0] t_in_data;
    typedef logic [OUT_DATA_W-1:0] t_out_data;

endpackage

// ===== hdl/two_field_heat_diffusion_step.sv =====
// Channel   | Port group           | Contents
// ----------+----------------------+----------------------------------------------
// input     | i_s_axis_*           | operation, cell_index, face_slot, face_kind,
//           |                      | neighbour_cell
// output    | o_m_axis_* / i_m_..  | field1_value, field2_value, status
// config    | i_cfg_*              | write enable, register index, data
//
// A load result is registered at the accepting edge; a read passes S_READ and S_READ2;
// set-initial writes every cell in use in S_INIT. A sweep goes per cell and field through
// an own fetch, then per face S_FACE, S_NB and S_ACC, two multiply passes and one finish;
// then each cell in use is committed in S_COMMIT. Every face and field goes through the
// single adder, and the gain multiply is one shared 19x24 multiplier used over two
// partial products per value. Memories need no clearing after reset; the block is not
// ready until the result of the previous transaction is taken.
module two_field_heat_diffusion_step (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // operation[1:0], cell_index[13:2], face_slot[16:14], face_kind[18:17],
    // neighbour_cell[30:19], zero pad
    input  hds_pkg::t_in_data        i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // field1_value[31:0], field2_value[63:32], status[65:64], zero pad
    output hds_pkg::t_out_data       o_m_axis_tdata,
    input  logic                     i_cfg_we,
    input  hds_pkg::t_cfg_idx        i_cfg_idx,
    input  hds_pkg::t_cfg_dat        i_cfg_data
);
    import hds_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int FAW = $clog2(MAX_CELLS * FACES);
    localparam int TW = TEMP_WIDTH;
    localparam int SW = TW + 5;          // exact sum of six terms
    localparam int CW = AW + 1;
    localparam int PW = SW + GAIN_W + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OWN = 4'd1;
    localparam logic [3:0] S_FACE = 4'd2;
    localparam logic [3:0] S_NB = 4'd3;
    localparam logic [3:0] S_ACC = 4'd4;
    localparam logic [3:0] S_MUL = 4'd5;
    localparam logic [3:0] S_FIN = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_CRD = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_INIT = 4'd10;
    localparam logic [3:0] S_READ = 4'd11;
    localparam logic [3:0] S_READ2 = 4'd12;

    logic [12:0] r_count;
    logic [GAIN_W-1:0] r_gain;
    logic signed [31:0] r_f1i, r_f2i, r_f1in, r_f1out, r_f2in, r_f2out;

    logic [TW-1:0] m_t1 [MAX_CELLS];
    logic [TW-1:0] m_t2 [MAX_CELLS];
    logic [TW-1:0] m_n1 [MAX_CELLS];
    logic [TW-1:0] m_n2 [MAX_CELLS];
    logic [KIND_W+AW-1:0] m_face [MAX_CELLS * FACES];

    logic [3:0] r_st;
    logic [CW-1:0] r_cnt, r_c;
    logic r_fld;
    logic [2:0] r_slot;
    logic [FAW-1:0] r_fa;
    logic signed [TW-1:0] r_own, r_rd1;
    logic [KIND_W+AW-1:0] r_face;
    logic r_face_in;
    logic signed [SW-1:0] r_sum;
    logic r_neg, r_sat;
    logic [SW-1:0] r_mag;
    logic [PW-1:0] r_prod;
    logic r_mph;
    logic [OUT_DATA_W-1:0] r_out;
    logic r_ovalid;

    logic [OP_W-1:0] in_op;
    logic [11:0] in_cell, in_nb;
    logic [2:0] in_slot;
    logic [KIND_W-1:0] in_kind;
    logic [CW-1:0] count_use;
    logic signed [TW-1:0] init1, init2;
    logic signed [TW:0] hi_lim, lo_lim;

    assign in_op = i_s_axis_tdata[1:0];
    assign in_cell = i_s_axis_tdata[13:2];
    assign in_slot = i_s_axis_tdata[16:14];
    assign in_kind = i_s_axis_tdata[18:17];
    assign in_nb = i_s_axis_tdata[30:19];
    assign count_use = (r_count > 13'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(r_count);
    assign hi_lim = (TW+1)'((64'sd1 <<< (TW-1)) - 1);
    assign lo_lim = -hi_lim - (TW+1)'(1);

    function automatic logic signed [TW-1:0] sat32(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'(hi_lim)) return TW'(hi_lim);
        if (w < 64'(lo_lim)) return TW'(lo_lim);
        return TW'(w);
    endfunction
    assign init1 = sat32(r_f1i);
    assign init2 = sat32(r_f2i);

    assign o_s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_gain <= '0;
            r_f1i <= '0; r_f2i <= '0; r_f1in <= '0; r_f1out <= '0;
            r_f2in <= '0; r_f2out <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COUNT: r_count <= i_cfg_data[12:0];
                REG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                REG_F1_INIT: r_f1i <= i_cfg_data;
                REG_F2_INIT: r_f2i <= i_cfg_data;
                REG_F1_IN: r_f1in <= i_cfg_data;
                REG_F1_OUT: r_f1out <= i_cfg_data;
                REG_F2_IN: r_f2in <= i_cfg_data;
                REG_F2_OUT: r_f2out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared adder operands
    logic signed [SW-1:0] add_a, add_b, add_y;
    logic signed [TW-1:0] fixed_t;
    logic [KIND_W-1:0] fk;
    logic [AW-1:0] fnb;
    assign fk = r_face[KIND_W+AW-1:AW];
    assign fnb = r_face[AW-1:0];
    assign fixed_t = (fk == KIND_INLET) ? (r_fld ? TW'(r_f2in) : TW'(r_f1in))
                                        : (r_fld ? TW'(r_f2out) : TW'(r_f1out));
    assign add_y = add_a + add_b;

    // shared 24-bit-by-half multiplier slice
    localparam int HW = (SW + 1) / 2;
    logic [HW-1:0] mul_x;
    logic [HW+GAIN_W-1:0] mul_y;
    assign mul_x = r_mph ? HW'(r_mag >> HW) : HW'(r_mag);
    assign mul_y = HW'(mul_x) * (HW+GAIN_W)'(r_gain);

    logic signed [SW+1:0] newv;
    logic [PW-1:0] q;
    assign q = (r_prod + (PW'(1) << (GAIN_W-1))) >> GAIN_W;

    always_comb begin
        add_a = r_sum;
        add_b = '0;
        unique case (r_st)
            S_NB: add_b = SW'(r_own);
            S_ACC: begin
                if (fk == KIND_LINK)
                    add_b = r_face_in ? SW'(r_rd1) - SW'(r_own) : '0;
                else if (fk == KIND_WALL)
                    add_b = '0;
                else
                    add_b = (SW'(fixed_t) - SW'(r_own)) <<< 1;
            end
            default: add_b = '0;
        endcase
    end
    assign newv = (SW+2)'(r_own) + (r_neg ? -(SW+2)'(q) : (SW+2)'(q));

    always_ff @(posedge i_clk) begin
        r_face <= m_face[r_fa];
        r_rd1 <= r_fld ? m_t2[fnb] : m_t1[fnb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_s_axis_tvalid && o_s_axis_tready) begin
                    r_sat <= 1'b0;
                    unique case (in_op)
                        OP_LOAD: begin
                            if (32'(in_cell) < MAX_CELLS && in_slot < 3'(FACES)) begin
                                m_face[FAW'(32'(in_cell) * FACES + 32'(in_slot))]
                                    <= {in_kind, AW'(in_nb)};
                                r_out <= '0;
                            end else
                                r_out <= OUT_DATA_W'({ST_RANGE, 64'd0});
                            r_ovalid <= 1'b1;
                        end
                        OP_INIT: begin
                            r_out <= '0;
                            r_c <= '0; r_st <= S_INIT;
                        end
                        OP_SWEEP: begin
                            r_out <= '0;
                            r_c <= '0; r_fld <= 1'b0; r_cnt <= count_use;
                            r_st <= (count_use == '0) ? S_OUT : S_OWN;
                        end
                        OP_READ: begin
                            if (CW'(in_cell) < count_use) begin
                                r_c <= CW'(in_cell); r_st <= S_READ;
                            end else begin
                                r_out <= OUT_DATA_W'({ST_RANGE, 64'd0}); r_ovalid <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_INIT: begin
                    if (r_c == count_use) begin
                        r_st <= S_IDLE; r_ovalid <= 1'b1;
                    end else begin
                        m_t1[r_c[AW-1:0]] <= init1;
                        m_t2[r_c[AW-1:0]] <= init2;
                        r_c <= r_c + 1'b1;
                    end
                end
                S_READ: begin
                    r_st <= S_READ2;
                    r_own <= m_t1[r_c[AW-1:0]];
                end
                S_READ2: begin
                    r_out <= OUT_DATA_W'({ST_OK, 32'(m_t2[r_c[AW-1:0]]), 32'(r_own)});
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                S_OWN: begin
                    r_own <= r_fld ? m_t2[r_c[AW-1:0]] : m_t1[r_c[AW-1:0]];
                    r_sum <= '0; r_slot <= '0;
                    r_fa <= FAW'(32'(r_c) * FACES);
                    r_st <= S_FACE;
                end
                S_FACE: r_st <= S_NB;   // face word registered
                S_NB: begin
                    r_face_in <= CW'(fnb) < r_cnt;
                    r_st <= S_ACC;      // neighbour temp registered
                end
                S_ACC: begin
                    r_sum <= add_y;
                    if (r_slot == 3'(FACES-1)) begin
                        r_st <= S_MUL; r_mph <= 1'b0; r_prod <= '0;
                        r_neg <= add_y < 0;
                        r_mag <= add_y < 0 ? SW'(-add_y) : SW'(add_y);
                    end else begin
                        r_slot <= r_slot + 1'b1; r_fa <= r_fa + 1'b1;
                        r_st <= S_FACE;
                    end
                end
                S_MUL: begin
                    if (r_mph) begin
                        r_prod <= r_prod + (PW'(mul_y) << HW);
                        r_st <= S_FIN;
                    end else r_prod <= PW'(mul_y);
                    r_mph <= !r_mph;
                end
                S_FIN: begin
                    logic signed [TW-1:0] v;
                    v = TW'(newv);
                    if (newv > (SW+2)'(hi_lim)) begin
                        v = TW'(hi_lim); r_sat <= 1'b1;
                    end else if (newv < (SW+2)'(lo_lim)) begin
                        v = TW'(lo_lim); r_sat <= 1'b1;
                    end
                    if (r_fld) m_n2[r_c[AW-1:0]] <= v;
                    else m_n1[r_c[AW-1:0]] <= v;
                    r_fld <= !r_fld;
                    if (r_fld && r_c + 1'b1 == r_cnt) begin
                        r_c <= '0; r_st <= S_COMMIT;
                    end else begin
                        if (r_fld) r_c <= r_c + 1'b1;
                        r_st <= S_OWN;
                    end
                end
                S_COMMIT: begin
                    m_t1[r_c[AW-1:0]] <= m_n1[r_c[AW-1:0]];
                    m_t2[r_c[AW-1:0]] <= m_n2[r_c[AW-1:0]];
                    if (r_c + 1'b1 == r_cnt) r_st <= S_OUT;
                    r_c <= r_c + 1'b1;
                end
                S_OUT: begin
                    r_out <= OUT_DATA_W'({r_sat ? ST_SAT : ST_OK, 64'd0});
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
